[rtl/core/murmur2_64a_hash_defines.svh]
// assertion macros for the murmur2 64a hash block
`ifndef MURMUR2_64A_HASH_DEFINES_SVH
`define MURMUR2_64A_HASH_DEFINES_SVH

`ifndef ASSERT_OFF
// checked property, quiet while reset is held
`define MH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hash block check failed");
// checked property, also live during reset
`define MH_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hash block reset check failed");
`else
`define MH_ASSERT(lbl, prop)
`define MH_ASSERT_RST(lbl, prop)
`endif

`endif

[rtl/core/mh64_pkg.sv]
`timescale 1ns / 1ps

package mh64_pkg;

  // mixing constants
  localparam logic [63:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT  = 47;
  localparam logic [63:0] SEED_RESET = 64'he6573480bcc4fcea;

  // how a word enters the hash
  typedef enum logic [1:0] {
    MIX_NONE = 2'd0,
    MIX_TAIL = 2'd1,
    MIX_FULL = 2'd2
  } mix_kind_t;

  // one classified word waiting in the queue
  typedef struct packed {
    logic [63:0] word;
    mix_kind_t   kind;
    logic [15:0] len;
    logic        first;
    logic        last;
  } q_entry_t;

  // status from the back part
  typedef struct packed {
    logic pop;
    logic emit;
  } back_stat_t;

endpackage

[rtl/core/mh64_mul.sv]
`timescale 1ns / 1ps

module mh64_mul import mh64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  output logic        done,
  output logic [63:0] res
);

  logic [63:0] pll;
  logic [31:0] plh;
  logic [31:0] phl;
  logic        v1;
  logic        v2;

  // stage one: partial products, only the low 64 bits of the full product matter
  always_ff @(posedge clk) begin
    pll <= {32'b0, a[31:0]} * {32'b0, MIX_MUL[31:0]};
    plh <= a[31:0] * MIX_MUL[63:32];
    phl <= a[63:32] * MIX_MUL[31:0];
  end

  // stage two: combine the partial products
  always_ff @(posedge clk) begin
    res <= pll + {plh + phl, 32'b0};
  end

  // valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
    end
  end

  assign done = v2;

endmodule

[rtl/core/mh64_front.sv]
`timescale 1ns / 1ps

module mh64_front import mh64_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] key_word,
  input  logic [3:0]  word_bytes,
  input  logic [15:0] key_length,
  input  logic        first_word,
  input  logic        last_word,
  output logic        q_valid,
  output q_entry_t    q_entry,
  input  back_stat_t  bk_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        cls;
  q_entry_t        qmem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  // classify the incoming beat and mask unused tail bytes
  always_comb begin
    cls.len   = key_length;
    cls.first = first_word;
    cls.last  = last_word;
    cls.word  = key_word;
    if (word_bytes[3]) begin
      cls.kind = MIX_FULL;
    end else if (word_bytes == 4'd0) begin
      cls.kind = MIX_NONE;
    end else begin
      cls.kind = MIX_TAIL;
    end
    if (!word_bytes[3]) begin
      for (int i = 0; i < 8; i++) begin
        if (3'(i) >= word_bytes[2:0]) begin
          cls.word[8*i +: 8] = 8'h00;
        end
      end
    end
  end

  assign in_ready = (count != CW'(DEPTH));
  assign q_valid  = (count != '0);
  assign q_entry  = qmem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = bk_stat.pop;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= cls;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/mh64_back.sv]
`timescale 1ns / 1ps

module mh64_back import mh64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] seed,
  input  logic        q_valid,
  input  q_entry_t    q_entry,
  output back_stat_t  bk_stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash_value
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_INIT = 7'b0000010,
    S_KEY1 = 7'b0000100,
    S_KEY2 = 7'b0001000,
    S_HASH = 7'b0010000,
    S_AVAL = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [63:0] hash;
  logic [63:0] hash_next;
  q_entry_t    ent;
  logic        mul_start;
  logic [63:0] mul_a;
  logic        mul_done;
  logic [63:0] mul_res;
  logic [63:0] xs;
  logic        mix_go;
  logic [63:0] mix_h;
  q_entry_t    mix_ent;
  logic        pop;
  logic        out_load;

  // shared multiply-by-constant unit
  mh64_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .done  (mul_done),
    .res   (mul_res)
  );

  assign xs = mul_res ^ (mul_res >> MIX_SHIFT);

  // sequencer: one multiply in flight at a time
  always_comb begin
    state_next = state;
    hash_next  = hash;
    mul_start  = 1'b0;
    mul_a      = '0;
    pop        = 1'b0;
    out_load   = 1'b0;
    mix_go     = 1'b0;
    mix_h      = hash;
    mix_ent    = ent;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_entry.first) begin
            mul_start  = 1'b1;
            mul_a      = 64'(q_entry.len);
            state_next = S_INIT;
          end else begin
            mix_go  = 1'b1;
            mix_ent = q_entry;
          end
        end
      end
      S_INIT: begin
        if (mul_done) begin
          mix_go = 1'b1;
          mix_h  = seed ^ mul_res;
        end
      end
      S_KEY1: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = xs;
          state_next = S_KEY2;
        end
      end
      S_KEY2: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = hash ^ mul_res;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (mul_done) begin
          hash_next = mul_res;
          if (ent.last) begin
            mul_start  = 1'b1;
            mul_a      = xs;
            state_next = S_AVAL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_AVAL: begin
        if (mul_done) begin
          hash_next  = xs;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // mix the word into a known starting hash
    if (mix_go) begin
      hash_next = mix_h;
      case (mix_ent.kind)
        MIX_FULL: begin
          mul_start  = 1'b1;
          mul_a      = mix_ent.word;
          state_next = S_KEY1;
        end
        MIX_TAIL: begin
          mul_start  = 1'b1;
          mul_a      = mix_h ^ mix_ent.word;
          state_next = S_HASH;
        end
        default: begin
          if (mix_ent.last) begin
            mul_start  = 1'b1;
            mul_a      = mix_h ^ (mix_h >> MIX_SHIFT);
            state_next = S_AVAL;
          end else begin
            state_next = S_IDLE;
          end
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hash      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      hash  <= hash_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      ent <= q_entry;
    end
    if (out_load) begin
      hash_value <= hash;
    end
  end

  assign bk_stat.pop  = pop;
  assign bk_stat.emit = out_load;

endmodule

[rtl/core/murmur2_64a_hash.sv]
`timescale 1ns / 1ps
// channel  | handshake            | beat
// ---------+----------------------+------------------------------------------------
// cfg      | cfg_valid/cfg_ready  | hash_seed
// in       | in_valid/in_ready    | key_word, word_bytes, key_length, first_word,
//          |                      | last_word
// out      | out_valid/out_ready  | hash_value
//
// each word runs through the back part as multiplies on the shared pipelined 64-bit
// multiplier: a full word needs three multiplies, a tail one, a first word adds one for
// the length term and a last word one for the avalanche plus a state to load the output
// register. the front queue takes beats while the back part works. reset (rst,
// synchronous) restores the default seed and clears the running hash. a stalled output
// holds the back part before the next word is popped; the queue takes beats until full.

`include "murmur2_64a_hash_defines.svh"

module murmur2_64a_hash import mh64_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] hash_seed,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] key_word,
  input  logic [3:0]  word_bytes,
  input  logic [15:0] key_length,
  input  logic        first_word,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash_value
);

  logic [63:0] seed;
  logic        q_valid;
  q_entry_t    q_entry;
  back_stat_t  bk_stat;

  assign cfg_ready = 1'b1;

  // seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      seed <= hash_seed;
    end
  end

  // front: classify and queue words
  mh64_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .key_word   (key_word),
    .word_bytes (word_bytes),
    .key_length (key_length),
    .first_word (first_word),
    .last_word  (last_word),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .bk_stat    (bk_stat)
  );

  // back: mixing sequencer and output register
  mh64_back u_back (
    .clk        (clk),
    .rst        (rst),
    .seed       (seed),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .bk_stat    (bk_stat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

  // checks
  `MH_ASSERT_RST(a_rst_out, rst |=> !out_valid)
  `MH_ASSERT(a_pop_has_item, bk_stat.pop |-> q_valid)
  `MH_ASSERT(a_out_from_emit, $rose(out_valid) |-> $past(bk_stat.emit))

endmodule
